// ----- design/aims_pkg.sv -----
// Shared types and constants for the affine inverse-map sampler.
package aims_pkg;

  localparam int COORD_W = 10;   // row / column field width
  localparam int PIX_W   = 24;   // pixel width
  localparam int COEF_W  = 24;   // Q8.16 matrix coefficient width
  localparam int ORG_W   = 13;   // signed origin width
  localparam int CTR_W   = 9;    // source center width
  localparam int FRAC_W  = 16;   // fraction bits of the coefficients
  localparam int IDX_W   = 3;    // register index width
  localparam int DATA_W  = 24;   // register write data width

  localparam logic [PIX_W-1:0]         WHITE      = 24'hFFFFFF;
  localparam logic signed [COEF_W-1:0] COEF_ONE   = 24'sd65536;
  localparam logic [CTR_W-1:0]         CENTER_RST = 9'd225;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_COEF_RR    = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_RC    = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_CR    = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_CC    = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW_ORIGIN = 3'd4;
  localparam logic [IDX_W-1:0] REG_COL_ORIGIN = 3'd5;
  localparam logic [IDX_W-1:0] REG_CENTER     = 3'd6;

  // Request type codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_MAP  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pixel_in;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             inside_res;
  } res_t;

endpackage

// ----- design/aims_ram.sv -----
// Generic single-write, single-read RAM with registered, read-first output.
module aims_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/affine_inverse_map_sampler_top.sv -----
// Top level of the affine inverse-map sampler (nearest-neighbour warp).
//
// Requests enter on req when start is high and busy is low; busy stays low,
// so one request can be taken every clock. A load request writes pixel_in
// into the source image at (row, col) and gives no result; loads outside
// the image are dropped. A map request gives one result on res, marked by
// a one-cycle done strobe. Throughput is one request per clock; the four
// 24x14 multipliers, the sum, the floor, the bounds check and the source
// image read each take their own stage. The receiver cannot stall: each
// result is shown for exactly one cycle. A load reaches the image through
// the ld_we delay line, ahead of the image read of every map transferred
// after it and behind the read of every map transferred before it, so
// each map sees exactly the loads ahead of it.
// Registers are written on the cfg channel (cfg_ready is always high) and
// must only change while no map request is in flight.
// Reset (rst, synchronous) empties the pipeline, drops loads not yet
// written, and restores the identity matrix, zero origins and a center of
// 225; the source image keeps no reset value and must be loaded before it
// is sampled.
module affine_inverse_map_sampler_top import aims_pkg::*; #(
  parameter int SRC_SIZE = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              req,
  output logic              done,
  output res_t              res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  localparam int CW    = $clog2(SRC_SIZE);
  localparam int DEPTH = SRC_SIZE * SRC_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CWP   = COORD_W + 1;
  localparam int DW    = COORD_W + 4;          // offset width, signed
  localparam int PW    = COEF_W + DW;          // product width
  localparam int SUMW  = PW + 1;               // sum width
  localparam int CRDW  = SUMW - FRAC_W + 1;    // source coordinate width
  localparam int LD_DLY = 4;                   // load write delay

  localparam logic [CWP-1:0]         LOAD_LIM = CWP'(SRC_SIZE);
  localparam logic signed [CRDW-1:0] SRC_LIM  = CRDW'(SRC_SIZE);
  localparam logic [AW-1:0]          ROW_STEP = AW'(SRC_SIZE);

  // Configuration registers
  logic signed [COEF_W-1:0] coef_rr, coef_rc, coef_cr, coef_cc;
  logic signed [ORG_W-1:0]  row_origin, col_origin;
  logic [CTR_W-1:0]         source_center;

  logic          acc;
  logic          load_we;
  logic [AW-1:0] load_addr;

  logic [LD_DLY-1:0] ld_we;
  logic [AW-1:0]     ld_addr [LD_DLY];
  logic [PIX_W-1:0]  ld_pix  [LD_DLY];

  logic                   s1_valid;
  logic signed [DW-1:0]   s1_dr, s1_dc;
  logic                   s2_valid;
  logic signed [PW-1:0]   s2_prr, s2_prc, s2_pcr, s2_pcc;
  logic                   s3_valid;
  logic signed [SUMW-1:0] s3_rsum, s3_csum;
  logic                   s4_valid;
  logic signed [CRDW-1:0] s4_srow, s4_scol;
  logic                   s5_valid;
  logic                   s5_inside;
  logic [AW-1:0]          s5_addr;
  logic                   s6_valid;
  logic                   s6_inside;
  logic [PIX_W-1:0]       rd_pixel;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_rr       <= COEF_ONE;
      coef_rc       <= '0;
      coef_cr       <= '0;
      coef_cc       <= COEF_ONE;
      row_origin    <= '0;
      col_origin    <= '0;
      source_center <= CENTER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_RR:    coef_rr       <= cfg_data[COEF_W-1:0];
        REG_COEF_RC:    coef_rc       <= cfg_data[COEF_W-1:0];
        REG_COEF_CR:    coef_cr       <= cfg_data[COEF_W-1:0];
        REG_COEF_CC:    coef_cc       <= cfg_data[COEF_W-1:0];
        REG_ROW_ORIGIN: row_origin    <= cfg_data[ORG_W-1:0];
        REG_COL_ORIGIN: col_origin    <= cfg_data[ORG_W-1:0];
        REG_CENTER:     source_center <= cfg_data[CTR_W-1:0];
        default: ;
      endcase
    end
  end

  // Drop loads outside the image.
  assign load_we = acc && (req.req_type == REQ_LOAD) &&
                   ({1'b0, req.row} < LOAD_LIM) && ({1'b0, req.col} < LOAD_LIM);
  assign load_addr = AW'(req.row[CW-1:0]) * ROW_STEP + AW'(req.col[CW-1:0]);

  // Hold each load back so it lands just after the reads of earlier maps.
  always_ff @(posedge clk) begin
    if (rst) begin
      ld_we <= '0;
    end else begin
      ld_we <= {ld_we[LD_DLY-2:0], load_we};
    end
  end

  always_ff @(posedge clk) begin
    ld_addr[0] <= load_addr;
    ld_pix[0]  <= req.pixel_in;
    for (int i = 1; i < LD_DLY; i++) begin
      ld_addr[i] <= ld_addr[i-1];
      ld_pix[i]  <= ld_pix[i-1];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= acc && (req.req_type == REQ_MAP);
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      done     <= s6_valid;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    s1_dr <= $signed({{(DW-COORD_W){1'b0}}, req.row}) - DW'(row_origin);
    s1_dc <= $signed({{(DW-COORD_W){1'b0}}, req.col}) - DW'(col_origin);

    s2_prr <= coef_rr * s1_dr;
    s2_prc <= coef_rc * s1_dc;
    s2_pcr <= coef_cr * s1_dr;
    s2_pcc <= coef_cc * s1_dc;

    s3_rsum <= SUMW'(s2_prr) + SUMW'(s2_prc);
    s3_csum <= SUMW'(s2_pcr) + SUMW'(s2_pcc);

    // Arithmetic shift floors toward minus infinity.
    s4_srow <= CRDW'(s3_rsum >>> FRAC_W) + $signed(CRDW'(source_center));
    s4_scol <= CRDW'(s3_csum >>> FRAC_W) + $signed(CRDW'(source_center));

    s5_inside <= !s4_srow[CRDW-1] && (s4_srow < SRC_LIM) &&
                 !s4_scol[CRDW-1] && (s4_scol < SRC_LIM);
    s5_addr   <= AW'(s4_srow[CW-1:0]) * ROW_STEP + AW'(s4_scol[CW-1:0]);

    s6_inside <= s5_inside;

    res.pixel_out  <= s6_inside ? rd_pixel : WHITE;
    res.inside_res <= s6_inside;
  end

  aims_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_image (
    .clk   (clk),
    .we    (ld_we[LD_DLY-1]),
    .waddr (ld_addr[LD_DLY-1]),
    .wdata (ld_pix[LD_DLY-1]),
    .raddr (s5_addr),
    .rdata (rd_pixel)
  );

endmodule

// ----- design/aims_checker.sv -----
// Port-level checks for the affine inverse-map sampler, bound to the top level.
module aims_checker import aims_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic done,
  input res_t res
);

  localparam int LATENCY = 7;

  logic map_xfer;
  logic load_xfer;

  assign map_xfer  = start && !busy && (req.req_type == REQ_MAP);
  assign load_xfer = start && !busy && (req.req_type == REQ_LOAD);

  // Every map transfer yields a result.
  a_map_gives_result: assert property (@(posedge clk) disable iff (rst)
    map_xfer |-> ##LATENCY done)
    else $error("map transfer gave no result");

  // A load transfer gives no result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    load_xfer |-> ##LATENCY !done)
    else $error("load transfer gave a result");

  // No result without a map transfer at the matching earlier edge.
  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(map_xfer, LATENCY))
    else $error("result without a map transfer");

  // An outside sample reads white.
  a_outside_white: assert property (@(posedge clk) disable iff (rst)
    (done && !res.inside_res) |-> (res.pixel_out == WHITE))
    else $error("outside sample not white");

endmodule

bind affine_inverse_map_sampler_top aims_checker u_aims_checker (.*);

// ----- dv/warp_checker.sv -----
// Checker for the affine warp sampler: predicts each map result and compares it.
`timescale 1ns / 100ps
module warp_checker import aims_pkg::*; #(
  parameter int SRC_SIZE = 512
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  req_t              req,
  input  logic              done,
  input  res_t              res,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending
);

  logic signed [COEF_W-1:0] w_rr, w_rc, w_cr, w_cc;
  logic signed [ORG_W-1:0]  org_row, org_col;
  logic [CTR_W-1:0]         ctr;
  logic [PIX_W-1:0]         src_pixels [SRC_SIZE*SRC_SIZE];
  res_t                     expected_pixels [$];
  int                       result_no;

  task automatic report(input string msg);
    fail_count++;
    $display("[%0t] result %0d: %s", $time, result_no, msg);
  endtask

  // Inverse-map one output pixel through the current matrix and sample the image.
  function automatic res_t sample_warp(input logic [COORD_W-1:0] r,
                                       input logic [COORD_W-1:0] c);
    longint dr, dc, sr, sc;
    res_t   o;
    dr = longint'(r) - longint'(org_row);
    dc = longint'(c) - longint'(org_col);
    sr = ((longint'(w_rr) * dr + longint'(w_rc) * dc) >>> FRAC_W) + longint'(ctr);
    sc = ((longint'(w_cr) * dr + longint'(w_cc) * dc) >>> FRAC_W) + longint'(ctr);
    if (sr >= 0 && sr < SRC_SIZE && sc >= 0 && sc < SRC_SIZE) begin
      o.pixel_out  = src_pixels[sr * SRC_SIZE + sc];
      o.inside_res = 1'b1;
    end else begin
      o.pixel_out  = WHITE;
      o.inside_res = 1'b0;
    end
    return o;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      w_rr       = COEF_ONE;
      w_rc       = '0;
      w_cr       = '0;
      w_cc       = COEF_ONE;
      org_row    = '0;
      org_col    = '0;
      ctr        = CENTER_RST;
      fail_count = 0;
      result_no  = 0;
      expected_pixels.delete();
    end else begin
      // results of this edge belong to transfers of earlier edges: check them first
      if (done) begin
        if (expected_pixels.size() == 0) begin
          report($sformatf("result with none expected: pixel_out %06h inside_res %0b",
                           res.pixel_out, res.inside_res));
        end else begin
          want = expected_pixels.pop_front();
          if (res.pixel_out !== want.pixel_out)
            report($sformatf("pixel_out %06h, expected %06h", res.pixel_out, want.pixel_out));
          if (res.inside_res !== want.inside_res)
            report($sformatf("inside_res %0b, expected %0b", res.inside_res, want.inside_res));
        end
        result_no++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COEF_RR:    w_rr    = cfg_data[COEF_W-1:0];
          REG_COEF_RC:    w_rc    = cfg_data[COEF_W-1:0];
          REG_COEF_CR:    w_cr    = cfg_data[COEF_W-1:0];
          REG_COEF_CC:    w_cc    = cfg_data[COEF_W-1:0];
          REG_ROW_ORIGIN: org_row = cfg_data[ORG_W-1:0];
          REG_COL_ORIGIN: org_col = cfg_data[ORG_W-1:0];
          REG_CENTER:     ctr     = cfg_data[CTR_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (req.req_type == REQ_MAP)
          expected_pixels.push_back(sample_warp(req.row, req.col));
        else if (req.row < SRC_SIZE && req.col < SRC_SIZE)
          src_pixels[req.row * SRC_SIZE + req.col] = req.pixel_in;
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// Stimulus and verdict for the affine inverse-map sampler.
`timescale 1ns / 100ps
module tb_top;
  import aims_pkg::*;

  localparam int SRC_SIZE = 512;
  localparam int LATENCY  = 7;
  localparam int PHASES   = 12;

  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;   // index with no register

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  req_t              req       = '0;
  logic              cfg_valid = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DATA_W-1:0] cfg_data  = '0;
  logic              busy, done, cfg_ready;
  res_t              res;
  int                fail_count, pending;

  // stimulus-side copy of the registers, used to steer maps onto loaded pixels
  logic signed [COEF_W-1:0] t_rr, t_rc, t_cr, t_cc;
  logic signed [ORG_W-1:0]  t_orow, t_ocol;
  logic [CTR_W-1:0]         t_ctr;
  bit                       loaded [SRC_SIZE*SRC_SIZE];
  bit                       burst;

  always #10 clk = ~clk;

  affine_inverse_map_sampler_top #(.SRC_SIZE(SRC_SIZE)) u_dut (
    .clk, .rst, .start, .busy, .req, .done, .res,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  warp_checker #(.SRC_SIZE(SRC_SIZE)) u_chk (
    .clk, .rst, .start, .busy, .req, .done, .res,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  function automatic int gap_len();
    int p;
    if (burst) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Source pixel a map lands on, if any, under the current settings.
  function automatic bit lands_on(input int r, input int c, output int idx);
    longint dr, dc, sr, sc;
    dr  = longint'(r) - longint'(t_orow);
    dc  = longint'(c) - longint'(t_ocol);
    sr  = ((longint'(t_rr) * dr + longint'(t_rc) * dc) >>> FRAC_W) + longint'(t_ctr);
    sc  = ((longint'(t_cr) * dr + longint'(t_cc) * dc) >>> FRAC_W) + longint'(t_ctr);
    idx = int'(sr * SRC_SIZE + sc);
    return sr >= 0 && sr < SRC_SIZE && sc >= 0 && sc < SRC_SIZE;
  endfunction

  function automatic int pick_coord(input logic signed [ORG_W-1:0] org);
    int v;
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, 1023);
    v = int'(org) + $urandom_range(0, 128) - 64;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
      req   = '{1'($urandom_range(0, 1)), COORD_W'($urandom_range(0, 1023)),
                COORD_W'($urandom_range(0, 1023)), PIX_W'($urandom_range(0, 24'hFFFFFF))};
    end
  endtask

  task automatic push_req(input logic kind, input int r, input int c,
                          input logic [PIX_W-1:0] pix);
    @(negedge clk);
    start = 1'b1;
    req   = '{req_type: kind, row: r[COORD_W-1:0], col: c[COORD_W-1:0], pixel_in: pix};
    do @(posedge clk); while (busy);
    if (kind == REQ_LOAD && r < SRC_SIZE && c < SRC_SIZE) loaded[r * SRC_SIZE + c] = 1'b1;
  endtask

  task automatic send_load(input int r, input int c, input logic [PIX_W-1:0] pix);
    push_req(REQ_LOAD, r, c, pix);
    idle(gap_len());
  endtask

  // Fill the target pixel first when it has never been loaded.
  task automatic send_map(input int r, input int c);
    int idx;
    if (lands_on(r, c, idx) && !loaded[idx])
      send_load(idx / SRC_SIZE, idx % SRC_SIZE, PIX_W'($urandom_range(0, 24'hFFFFFF)));
    push_req(REQ_MAP, r, c, PIX_W'($urandom_range(0, 24'hFFFFFF)));
    idle(gap_len());
  endtask

  // Hold off until every map result is back; with full, let the pipe drain too.
  task automatic settle(input bit full);
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    if (full) repeat (LATENCY + 3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COEF_RR:    t_rr   = val[COEF_W-1:0];
      REG_COEF_RC:    t_rc   = val[COEF_W-1:0];
      REG_COEF_CR:    t_cr   = val[COEF_W-1:0];
      REG_COEF_CC:    t_cc   = val[COEF_W-1:0];
      REG_ROW_ORIGIN: t_orow = val[ORG_W-1:0];
      REG_COL_ORIGIN: t_ocol = val[ORG_W-1:0];
      REG_CENTER:     t_ctr  = val[CTR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
    repeat ($urandom_range(0, 2)) @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_coef();
    if ($urandom_range(0, 7) == 0) return DATA_W'($urandom);
    return DATA_W'($urandom_range(0, 262144) - 131072);   // within +/-2.0
  endfunction

  // Narrow registers get junk above their width now and then.
  function automatic logic [DATA_W-1:0] rand_narrow(input int w, input int val);
    logic [DATA_W-1:0] v;
    v = DATA_W'(val);
    v = v & DATA_W'((1 << w) - 1);
    if ($urandom_range(0, 3) == 0) v = v | DATA_W'($urandom << w);
    return v;
  endfunction

  task automatic setup_phase(input int p);
    case (p)
      1: begin
        write_reg(REG_COEF_RR, 24'h7FFFFF);
        write_reg(REG_COEF_RC, 24'h7FFFFF);
        write_reg(REG_COEF_CR, 24'h7FFFFF);
        write_reg(REG_COEF_CC, 24'h7FFFFF);
        write_reg(REG_ROW_ORIGIN, 24'h000FFF);
        write_reg(REG_COL_ORIGIN, 24'h000FFF);
        write_reg(REG_CENTER, 24'h0001FF);
      end
      2: begin
        write_reg(REG_COEF_RR, 24'h800000);
        write_reg(REG_COEF_RC, 24'h800000);
        write_reg(REG_COEF_CR, 24'h800000);
        write_reg(REG_COEF_CC, 24'h800000);
        write_reg(REG_ROW_ORIGIN, 24'h001000);
        write_reg(REG_COL_ORIGIN, 24'h001000);
        write_reg(REG_CENTER, 24'h000000);
      end
      3: begin
        // steepest mirror on rows, steepest gain on columns
        write_reg(REG_COEF_RR, 24'h800000);
        write_reg(REG_COEF_RC, '0);
        write_reg(REG_COEF_CR, '0);
        write_reg(REG_COEF_CC, 24'h7FFFFF);
        write_reg(REG_ROW_ORIGIN, 24'd512);
        write_reg(REG_COL_ORIGIN, 24'd512);
        write_reg(REG_CENTER, 24'd256);
      end
      default: begin
        if ($urandom_range(0, 3) != 0) write_reg(REG_COEF_RR, rand_coef());
        if ($urandom_range(0, 3) != 0) write_reg(REG_COEF_RC, rand_coef());
        if ($urandom_range(0, 3) != 0) write_reg(REG_COEF_CR, rand_coef());
        if ($urandom_range(0, 3) != 0) write_reg(REG_COEF_CC, rand_coef());
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_ROW_ORIGIN, rand_narrow(ORG_W, ($urandom_range(0, 7) == 0) ?
                                                 $urandom : $urandom_range(0, 1023)));
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_COL_ORIGIN, rand_narrow(ORG_W, ($urandom_range(0, 7) == 0) ?
                                                 $urandom : $urandom_range(0, 1023)));
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_CENTER, rand_narrow(CTR_W, $urandom_range(0, 511)));
        // unused index: must leave every register alone
        if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, DATA_W'($urandom));
      end
    endcase
  endtask

  task automatic random_items(input int n, input int p);
    int k, r, c;
    for (k = 0; k < n; k++) begin
      if ((p == 4 && k == n / 2) || $urandom_range(0, 149) == 0) settle(1'b0);
      if ($urandom_range(0, 9) < 4) begin
        r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 511);
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 511);
        send_load(r, c, PIX_W'($urandom_range(0, 24'hFFFFFF)));
      end else begin
        r = pick_coord(t_orow);
        c = pick_coord(t_ocol);
        send_map(r, c);
      end
    end
  endtask

  initial begin
    t_rr   = COEF_ONE;
    t_rc   = '0;
    t_cr   = '0;
    t_cc   = COEF_ONE;
    t_orow = '0;
    t_ocol = '0;
    t_ctr  = CENTER_RST;
    burst  = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);

    // reset settings: identity, zero origins, center 225
    send_map(0, 0);
    send_map(286, 286);      // lands on the last row and column
    send_map(287, 100);      // one row past the image
    send_map(100, 287);
    send_map(1023, 1023);
    send_map(1023, 0);
    settle(1'b1);
    write_reg(REG_CENTER, '0);
    send_load(0, 0, 24'h000000);
    send_load(512, 0, 24'hABCDEF);   // outside the image: must not alias onto row 0
    send_load(0, 512, 24'h5A5A5A);
    send_load(1023, 1023, 24'hFFFFFF);
    send_load(511, 511, 24'hFFFFFF);
    send_map(0, 0);
    send_map(511, 511);
    send_map(512, 0);
    send_map(0, 512);
    burst = 1'b1;
    send_load(0, 0, 24'h800001);     // overwrite and map the pixel on the next clock
    send_map(0, 0);
    send_load(0, 0, 24'h13579B);     // right behind the map: must not reach it
    send_map(0, 0);

    for (int p = 1; p < PHASES; p++) begin
      settle(1'b1);
      setup_phase(p);
      burst = ($urandom_range(0, 3) == 0);
      random_items((p <= 2) ? 40 : 150, p);
    end

    settle(1'b1);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
